// ----- hw/rtl/gfsd_pkg.sv -----
// ----------------------------------------------------------------------------
// gfsd_pkg
// Shared types, constants and helper functions of the grayscale
// Floyd-Steinberg dither unit.
// ----------------------------------------------------------------------------
package gfsd_pkg;

   // configuration
   localparam int                 MAX_WIDTH_DEFAULT    = 2048;
   localparam int                 IMAGE_WIDTH_W        = 12;
   localparam logic [11:0]        IMAGE_WIDTH_RESET    = 12'd640;
   localparam int                 CSR_ADDR_W           = 3;
   localparam int                 CSR_DATA_W           = 32;
   localparam logic [2:0]         CSR_ADDR_IMAGE_WIDTH = 3'd0;

   // stream payloads
   localparam int                 RGB_W      = 24;
   localparam int                 GRAY_W     = 8;
   localparam int                 RSP_DATA_W = 16;

   // luma weights in 256ths
   localparam logic [15:0]        WEIGHT_RED   = 16'd77;
   localparam logic [15:0]        WEIGHT_GREEN = 16'd151;
   localparam logic [15:0]        WEIGHT_BLUE  = 16'd28;

   // quantiser
   localparam logic signed [9:0]  THRESHOLD   = 10'sd127;
   localparam logic signed [9:0]  LEVEL_WHITE = 10'sd255;
   localparam logic signed [10:0] CORR_MIN    = -11'sd256;
   localparam logic signed [10:0] CORR_MAX    = 11'sd511;

   // error storage in sixteenths
   localparam int                 ERR_W       = 13;
   localparam logic signed [13:0] ERR_SUM_MIN = -14'sd4096;
   localparam logic signed [13:0] ERR_SUM_MAX = 14'sd4095;

   typedef logic signed [ERR_W-1:0] err_type;

   // control of the pixel held in the input stage
   typedef struct packed {
      logic              valid;
      logic              first_row;
      logic              col_zero;
      logic              last_col;
      logic [GRAY_W-1:0] gray;
   } pix_ctl_type;

   // write request into the line buffer
   typedef struct packed {
      logic    en;
      err_type data;
   } lb_wr_type;

   // (77r + 151g + 28b) >> 8
   function automatic logic [GRAY_W-1:0] rgb_to_gray(input logic [RGB_W-1:0] rgb);
      logic [15:0] sum;
      sum = WEIGHT_RED * 16'(rgb[23:16]) + WEIGHT_GREEN * 16'(rgb[15:8])
          + WEIGHT_BLUE * 16'(rgb[7:0]);
      return sum[15:8];
   endfunction

   // saturate a grown error sum to the stored range
   function automatic err_type clamp_err(input logic signed [13:0] v);
      err_type r;
      if (v < ERR_SUM_MIN) begin
         r = err_type'(ERR_SUM_MIN[12:0]);
      end else if (v > ERR_SUM_MAX) begin
         r = err_type'(ERR_SUM_MAX[12:0]);
      end else begin
         r = err_type'(v[12:0]);
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/gfsd_line_buffer.sv -----
// ----------------------------------------------------------------------------
// gfsd_line_buffer
// Error line memory, one write and one registered read per cycle. The read
// register follows later writes to the address it holds.
// ----------------------------------------------------------------------------
module gfsd_line_buffer #(
   parameter int MAX_WIDTH = gfsd_pkg::MAX_WIDTH_DEFAULT,
   localparam int AW = $clog2(MAX_WIDTH)
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output gfsd_pkg::err_type   rd_data,
   input  gfsd_pkg::lb_wr_type wr,
   input  logic [AW-1:0]       wr_addr
);

   gfsd_pkg::err_type mem [MAX_WIDTH];
   gfsd_pkg::err_type rd_data_ff;
   logic [AW-1:0]     rd_addr_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
   end

   // read port with write-through to the held word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_addr_ff <= rd_addr;
         if (wr.en && wr_addr == rd_addr) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end else if (wr.en && wr_addr == rd_addr_ff) begin
         rd_data_ff <= wr.data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/gfsd_front.sv -----
// ----------------------------------------------------------------------------
// gfsd_front
// Input stage: takes pixels, tracks column and first row, forms the gray
// level and starts the line buffer read for the pixel's column.
// ----------------------------------------------------------------------------
module gfsd_front #(
   parameter int MAX_WIDTH = gfsd_pkg::MAX_WIDTH_DEFAULT,
   localparam int AW = $clog2(MAX_WIDTH),
   localparam int WW = $clog2(MAX_WIDTH + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [gfsd_pkg::RGB_W-1:0]     req_tdata,
   input  logic                           req_tuser,
   input  logic [WW-1:0]                  width_use,
   input  logic                           fire,
   output gfsd_pkg::pix_ctl_type          stg_ctl,
   output logic [AW-1:0]                  stg_col,
   output logic                           rd_en,
   output logic [AW-1:0]                  rd_addr
);

   logic                  accept;
   logic [AW-1:0]         col_ff, col_in;
   logic                  first_ff, first_in;
   gfsd_pkg::pix_ctl_type stg_ff, stg_in;
   logic [AW-1:0]         stg_col_ff;
   logic [AW-1:0]         col_cur;
   logic                  first_cur;
   logic                  last_cur;

   assign req_tready = !stg_ff.valid || fire;
   assign accept     = req_tvalid && req_tready;

   // column of the arriving pixel: frame start, then overrun of a lowered width
   always_comb begin
      col_cur   = req_tuser ? '0 : col_ff;
      first_cur = req_tuser ? 1'b1 : first_ff;
      if (!req_tuser && WW'(col_ff) >= width_use) begin
         col_cur   = '0;
         first_cur = 1'b0;
      end
      last_cur = (WW'(col_cur) + WW'(1)) >= width_use;
   end

   // position for the next pixel
   always_comb begin
      col_in   = col_ff;
      first_in = first_ff;
      if (accept) begin
         col_in   = last_cur ? '0 : col_cur + AW'(1);
         first_in = last_cur ? 1'b0 : first_cur;
      end
   end

   // stage register contents
   always_comb begin
      stg_in = stg_ff;
      if (accept) begin
         stg_in.valid     = 1'b1;
         stg_in.first_row = first_cur;
         stg_in.col_zero  = (col_cur == '0);
         stg_in.last_col  = last_cur;
         stg_in.gray      = gfsd_pkg::rgb_to_gray(req_tdata);
      end else if (fire) begin
         stg_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         first_ff     <= 1'b1;
         stg_ff.valid <= 1'b0;
      end else begin
         col_ff       <= col_in;
         first_ff     <= first_in;
         stg_ff.valid <= stg_in.valid;
      end
      // stage payload
      stg_ff.first_row <= stg_in.first_row;
      stg_ff.col_zero  <= stg_in.col_zero;
      stg_ff.last_col  <= stg_in.last_col;
      stg_ff.gray      <= stg_in.gray;
      if (accept) begin
         stg_col_ff <= col_cur;
      end
   end

   assign stg_ctl = stg_ff;
   assign stg_col = stg_col_ff;
   assign rd_en   = accept;
   assign rd_addr = col_cur;

endmodule

// ----- hw/rtl/gfsd_diffuse.sv -----
// ----------------------------------------------------------------------------
// gfsd_diffuse
// Error correction, threshold and error spreading for the staged pixel,
// with the neighbour carries, the line buffer writes and the result register.
// ----------------------------------------------------------------------------
module gfsd_diffuse #(
   parameter int MAX_WIDTH = gfsd_pkg::MAX_WIDTH_DEFAULT,
   localparam int AW = $clog2(MAX_WIDTH)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  gfsd_pkg::pix_ctl_type              stg_ctl,
   input  logic [AW-1:0]                      stg_col,
   input  gfsd_pkg::err_type                  rd_data,
   output logic                               fire,
   output gfsd_pkg::lb_wr_type                wr,
   output logic [AW-1:0]                      wr_addr,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [gfsd_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   gfsd_pkg::err_type       above, right_use, bl_use, b_use;
   logic signed [13:0]      acc;
   logic signed [9:0]       acc_q;
   logic signed [10:0]      corr_raw;
   logic signed [9:0]       corr;
   logic                    white;
   logic signed [9:0]       err;
   gfsd_pkg::err_type       err3, err5, err7;
   gfsd_pkg::err_type       bl_sum, b_sum;
   logic                    main_we;
   logic [AW-1:0]           main_addr;
   gfsd_pkg::err_type       main_data;
   logic                    dw_new;

   gfsd_pkg::err_type       right_ff, pend_bl_ff, pend_b_ff;
   logic                    dw_valid_ff, dw_valid_in;
   logic [AW-1:0]           dw_addr_ff;
   gfsd_pkg::err_type       dw_data_ff;
   logic                    out_valid_ff, out_valid_in;
   logic                    out_white_ff;
   logic [gfsd_pkg::GRAY_W-1:0] out_gray_ff;

   assign fire = stg_ctl.valid && (!out_valid_ff || rsp_tready);

   // corrected level and quantisation
   always_comb begin
      above     = stg_ctl.first_row ? '0 : rd_data;
      right_use = stg_ctl.col_zero ? '0 : right_ff;
      bl_use    = stg_ctl.col_zero ? '0 : pend_bl_ff;
      b_use     = stg_ctl.col_zero ? '0 : pend_b_ff;
      acc       = 14'(above) + 14'(right_use);
      acc_q     = 10'(acc >>> 4);
      corr_raw  = $signed({3'b000, stg_ctl.gray}) + 11'(acc_q);
      if (corr_raw < gfsd_pkg::CORR_MIN) begin
         corr = 10'(gfsd_pkg::CORR_MIN);
      end else if (corr_raw > gfsd_pkg::CORR_MAX) begin
         corr = 10'(gfsd_pkg::CORR_MAX);
      end else begin
         corr = 10'(corr_raw);
      end
      white = corr > gfsd_pkg::THRESHOLD;
      err   = white ? corr - gfsd_pkg::LEVEL_WHITE : corr;
   end

   // shares in sixteenths
   always_comb begin
      err3   = gfsd_pkg::err_type'(13'(err) * 13'sd3);
      err5   = gfsd_pkg::err_type'(13'(err) * 13'sd5);
      err7   = gfsd_pkg::err_type'(13'(err) * 13'sd7);
      bl_sum = gfsd_pkg::clamp_err(14'(bl_use) + 14'(err3));
      b_sum  = gfsd_pkg::clamp_err(14'(b_use) + 14'(err5));
   end

   // below-left goes out at once; below of a last column is held in the deferred
   // write register unless it is also the first column
   always_comb begin
      main_we   = fire && (!stg_ctl.col_zero || stg_ctl.last_col);
      main_addr = stg_ctl.col_zero ? '0 : stg_col - AW'(1);
      main_data = stg_ctl.col_zero ? b_sum : bl_sum;
      dw_new    = fire && stg_ctl.last_col && !stg_ctl.col_zero;
      wr.en     = main_we || dw_valid_ff;
      wr.data   = main_we ? main_data : dw_data_ff;
      wr_addr   = main_we ? main_addr : dw_addr_ff;
   end

   always_comb begin
      dw_valid_in = dw_valid_ff;
      if (dw_new) begin
         dw_valid_in = 1'b1;
      end else if (!main_we) begin
         dw_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dw_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         dw_valid_ff  <= dw_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // neighbour carries, deferred write and result payload
   always_ff @(posedge clock) begin
      if (fire && !stg_ctl.last_col) begin
         pend_bl_ff <= b_sum;
         pend_b_ff  <= gfsd_pkg::err_type'(err);
         right_ff   <= err7;
      end
      if (dw_new) begin
         dw_addr_ff <= stg_col;
         dw_data_ff <= b_sum;
      end
      if (fire) begin
         out_white_ff <= white;
         out_gray_ff  <= stg_ctl.gray;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0000000, out_gray_ff, out_white_ff};

   // the deferred write never meets a second write in its cycle
   a_dw_no_clash: assert property (@(posedge clock) disable iff (reset)
      dw_valid_ff |-> !main_we)
      else $error("deferred line write clashes with a pixel write");

   // a first-column pixel writes the line only when it also ends the row
   a_col0_write: assert property (@(posedge clock) disable iff (reset)
      (main_we && stg_ctl.col_zero) |-> stg_ctl.last_col)
      else $error("first column wrote the line buffer mid row");

   // a processed pixel always lands in the result register
   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("processed pixel lost before the result register");

endmodule

// ----- hw/rtl/gray_floyd_steinberg_dither_unit.sv -----
// ----------------------------------------------------------------------------
// gray_floyd_steinberg_dither_unit
// RGB888 to gray conversion followed by Floyd-Steinberg error diffusion to
// one bit per pixel.
//
//   channel  direction  handshake                  payload
//   req_     in         tvalid / tready            tdata: pixel_rgb, tuser: start_of_frame
//   rsp_     out        tvalid / tready            tdata: out_white, gray_level
//   csr_     in         psel / penable / pready    image_width at byte address 0
//
// One pixel per clock sustained while the result side accepts; a pixel passes
// through the input stage register (with the line buffer read), then the error
// stage into the result register.
// The registered neighbour carry between consecutive pixels sets that rate.
// Synchronous active-high reset clears control state; the error line holds
// no defined value after reset and is written before any row reads it.
// A stalled result register holds its pixel while one more is staged.
// ----------------------------------------------------------------------------
module gray_floyd_steinberg_dither_unit #(
   parameter int MAX_WIDTH = gfsd_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // pixel input
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gfsd_pkg::RGB_W-1:0]          req_tdata,  // [23:0] pixel_rgb
   input  logic                                req_tuser,  // [0] start_of_frame
   // dithered output
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gfsd_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [0] out_white, [8:1] gray_level
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [gfsd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [gfsd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [gfsd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W = (WW > gfsd_pkg::IMAGE_WIDTH_W) ? WW : gfsd_pkg::IMAGE_WIDTH_W;

   logic [gfsd_pkg::IMAGE_WIDTH_W-1:0] width_ff, width_in;
   logic [WW-1:0]                      width_use;
   logic                               csr_wr;
   gfsd_pkg::pix_ctl_type              stg_ctl;
   logic [AW-1:0]                      stg_col;
   logic                               fire;
   logic                               rd_en;
   logic [AW-1:0]                      rd_addr;
   gfsd_pkg::err_type                  rd_data;
   gfsd_pkg::lb_wr_type                lb_wr;
   logic [AW-1:0]                      lb_wr_addr;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_in = width_ff;
      if (csr_wr && csr_paddr == gfsd_pkg::CSR_ADDR_IMAGE_WIDTH) begin
         width_in = csr_pwdata[gfsd_pkg::IMAGE_WIDTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= gfsd_pkg::IMAGE_WIDTH_RESET;
      end else begin
         width_ff <= width_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == gfsd_pkg::CSR_ADDR_IMAGE_WIDTH) begin
         csr_prdata = gfsd_pkg::CSR_DATA_W'(width_ff);
      end
   end

   // width in use: zero means one, capped at the line buffer depth
   always_comb begin
      if (width_ff == '0) begin
         width_use = WW'(1);
      end else if (CMP_W'(width_ff) > CMP_W'(MAX_WIDTH)) begin
         width_use = WW'(MAX_WIDTH);
      end else begin
         width_use = WW'(width_ff);
      end
   end

   gfsd_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .width_use  (width_use),
      .fire       (fire),
      .stg_ctl    (stg_ctl),
      .stg_col    (stg_col),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr)
   );

   gfsd_line_buffer #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buffer (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr      (lb_wr),
      .wr_addr (lb_wr_addr)
   );

   gfsd_diffuse #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_diffuse (
      .clock      (clock),
      .reset      (reset),
      .stg_ctl    (stg_ctl),
      .stg_col    (stg_col),
      .rd_data    (rd_data),
      .fire       (fire),
      .wr         (lb_wr),
      .wr_addr    (lb_wr_addr),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
